// ===== rtl/grfa_pkg.sv =====
// Package for the grid rectangle first-fit allocator.
// Types, constants and state codes; no dependencies.
`default_nettype none
package grfa_pkg;
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS = 16;
  localparam int ID_BITS = 8;
  localparam int CELL_TOTAL = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_BITS = $clog2(CELL_TOTAL);
  localparam int XB = $clog2(MAX_COLUMNS + 1);
  localparam int YB = $clog2(MAX_ROWS + 1);

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_BADID = 2'd2;
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] item_id;
    logic [4:0] item_width;
    logic [4:0] item_height;
    logic [7:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] placed_column;
    logic [3:0] placed_row;
    logic [7:0] cell_owner;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHK_RD, S_CHK_EV, S_FILL, S_REM_RD, S_REM_EV,
    S_LK_RD, S_LK_EV, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/grid_rectangle_first_fit_allocator.sv =====
// Top level of the grid rectangle first-fit allocator.
// Dual-port cell memory with a read-evaluate sequencer; uses grfa_pkg.
//
// channel | direction | handshake
// in      | input     | in_valid / in_ready, struct in_item_t
// out     | output    | out_valid / out_ready, struct out_item_t
// cfg     | input     | cfg_we, cfg_index, cfg_data
//
// After reset a clearing pass zeroes every cell of the memory; no transfer in.
// Add: each cell checked is read, then evaluated, over each candidate
// position in turn, then one write per filled cell.
// Remove: a read then an evaluate per entry. Lookup: a read then an evaluate.
// A held result stalls the next request until it is taken.
`default_nettype none
module grid_rectangle_first_fit_allocator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire grfa_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output grfa_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [4:0] cfg_data
);
  localparam int AB = grfa_pkg::ADDR_BITS;
  localparam int XB = grfa_pkg::XB;
  localparam int YB = grfa_pkg::YB;

  logic [grfa_pkg::ID_BITS-1:0] mem [grfa_pkg::CELL_TOTAL];
  logic [grfa_pkg::ID_BITS-1:0] rdata;
  logic [AB-1:0] raddr, waddr;
  logic we;
  logic [grfa_pkg::ID_BITS-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [4:0] col_reg, row_reg;
  grfa_pkg::state_t state, state_next;
  grfa_pkg::in_item_t req;
  logic [XB-1:0] cols, px, ox;
  logic [YB-1:0] rows, py, oy;
  logic [AB:0] cnt;
  logic [XB-1:0] px_next, ox_next;
  logic [YB-1:0] py_next, oy_next;
  logic [AB:0] cnt_next;
  grfa_pkg::out_item_t res, res_next;
  logic [grfa_pkg::ID_BITS-1:0] rid;
  logic [9:0] cell_a;

  always_comb begin
    cols = (col_reg == 5'd0) ? XB'(1) :
           (col_reg > 5'(grfa_pkg::MAX_COLUMNS)) ? XB'(grfa_pkg::MAX_COLUMNS) : XB'(col_reg);
    rows = (row_reg == 5'd0) ? YB'(1) :
           (row_reg > 5'(grfa_pkg::MAX_ROWS)) ? YB'(grfa_pkg::MAX_ROWS) : YB'(row_reg);
  end

  assign rid = req.item_id[grfa_pkg::ID_BITS-1:0];
  assign cell_a = 10'(({5'd0, py} + {5'd0, oy}) * cols) + 10'(px) + 10'(ox);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_reg <= 5'd8;
      row_reg <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        grfa_pkg::REG_COLS: col_reg <= cfg_data;
        grfa_pkg::REG_ROWS: row_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    px_next = px; py_next = py; ox_next = ox; oy_next = oy;
    cnt_next = cnt; res_next = res;
    we = 1'b0; waddr = cnt[AB-1:0]; wdata = '0;
    raddr = AB'(cell_a);
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      grfa_pkg::S_CLEAR: begin
        we = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == (AB+1)'(grfa_pkg::CELL_TOTAL - 1)) state_next = grfa_pkg::S_IDLE;
      end
      grfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        px_next = '0; py_next = '0; ox_next = '0; oy_next = '0;
        cnt_next = '0;
        res_next = '0;
        res_next.status = grfa_pkg::ST_FAIL;
        if (in_valid) begin
          state_next = grfa_pkg::S_DONE;
          case (in_data.mode)
            grfa_pkg::MODE_ADD:
              if (in_data.item_id[grfa_pkg::ID_BITS-1:0] == '0)
                res_next.status = grfa_pkg::ST_BADID;
              else if (in_data.item_width != 0 && in_data.item_height != 0 &&
                       in_data.item_width <= 5'(cols) && in_data.item_height <= 5'(rows))
                state_next = grfa_pkg::S_CHK_RD;
            grfa_pkg::MODE_REMOVE:
              if (in_data.item_id[grfa_pkg::ID_BITS-1:0] == '0)
                res_next.status = grfa_pkg::ST_BADID;
              else state_next = grfa_pkg::S_REM_RD;
            grfa_pkg::MODE_LOOKUP:
              if (9'(in_data.cell_index) < 9'(cols * rows)) state_next = grfa_pkg::S_LK_RD;
            default: ;
          endcase
        end
      end
      grfa_pkg::S_CHK_RD: state_next = grfa_pkg::S_CHK_EV;
      grfa_pkg::S_CHK_EV: begin
        if (rdata != '0) begin
          ox_next = '0; oy_next = '0;
          if (5'(px) + req.item_width < 5'(cols) + 5'd1 - 5'd1 &&
              5'(px) + 5'd1 + req.item_width <= 5'(cols)) begin
            px_next = px + 1'b1;
            state_next = grfa_pkg::S_CHK_RD;
          end else begin
            px_next = '0;
            if (5'(py) + 5'd1 + req.item_height <= 5'(rows)) begin
              py_next = py + 1'b1;
              state_next = grfa_pkg::S_CHK_RD;
            end else state_next = grfa_pkg::S_DONE;
          end
        end else if (5'(ox) + 5'd1 < req.item_width) begin
          ox_next = ox + 1'b1;
          state_next = grfa_pkg::S_CHK_RD;
        end else if (5'(oy) + 5'd1 < req.item_height) begin
          ox_next = '0; oy_next = oy + 1'b1;
          state_next = grfa_pkg::S_CHK_RD;
        end else begin
          ox_next = '0; oy_next = '0;
          state_next = grfa_pkg::S_FILL;
        end
      end
      grfa_pkg::S_FILL: begin
        we = 1'b1; waddr = AB'(cell_a); wdata = rid;
        if (5'(ox) + 5'd1 < req.item_width) ox_next = ox + 1'b1;
        else if (5'(oy) + 5'd1 < req.item_height) begin
          ox_next = '0; oy_next = oy + 1'b1;
        end else begin
          res_next.status = grfa_pkg::ST_OK;
          res_next.placed_column = 4'(px);
          res_next.placed_row = 4'(py);
          state_next = grfa_pkg::S_DONE;
        end
      end
      grfa_pkg::S_REM_RD: begin
        raddr = cnt[AB-1:0];
        state_next = grfa_pkg::S_REM_EV;
      end
      grfa_pkg::S_REM_EV: begin
        if (rdata == rid) begin
          we = 1'b1;
          res_next.status = grfa_pkg::ST_OK;
        end
        cnt_next = cnt + 1'b1;
        state_next = (cnt == (AB+1)'(grfa_pkg::CELL_TOTAL - 1)) ?
                     grfa_pkg::S_DONE : grfa_pkg::S_REM_RD;
      end
      grfa_pkg::S_LK_RD: begin
        raddr = AB'(req.cell_index);
        state_next = grfa_pkg::S_LK_EV;
      end
      grfa_pkg::S_LK_EV: begin
        res_next.status = grfa_pkg::ST_OK;
        res_next.cell_owner = 8'(rdata);
        state_next = grfa_pkg::S_DONE;
      end
      grfa_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = grfa_pkg::S_IDLE;
      end
      default: state_next = grfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grfa_pkg::S_CLEAR;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
    px <= px_next; py <= py_next; ox <= ox_next; oy <= oy_next;
    res <= res_next;
    if (in_ready && in_valid) req <= in_data;
  end

  assign out_data = res;
endmodule
`default_nettype wire

// ===== rtl/grfa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
// Uses grfa_pkg for the payload types.
`default_nettype none
module grfa_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire grfa_pkg::out_item_t out_data
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result held");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != grfa_pkg::ST_OK |->
    out_data.placed_column == 4'd0 && out_data.placed_row == 4'd0)
    else $error("position on failure");
endmodule

bind grid_rectangle_first_fit_allocator grfa_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ===== dv/tb_grid_rectangle_first_fit_allocator.sv =====
// Self-checking testbench for grid_rectangle_first_fit_allocator.
// Drives add, remove, lookup and invalid-mode requests over several grid sizes and
// predicts every result in a scoreboard class; depends on grfa_pkg and the RTL only.
`timescale 1ns / 100ps
module tb_grid_rectangle_first_fit_allocator;

  localparam int LIMIT = 40_000_000;
  localparam int NPHASE = 9;

  class grid_scoreboard;
    logic [7:0] cells [grfa_pkg::CELL_TOTAL];
    logic [4:0] col_reg, row_reg;
    grfa_pkg::out_item_t answers [$];
    int fails;

    function new();
      foreach (cells[i]) cells[i] = '0;
      col_reg = 5'd8;
      row_reg = 5'd4;
      fails = 0;
    endfunction

    function void configure(logic idx, logic [4:0] v);
      if (idx == grfa_pkg::REG_COLS) col_reg = v;
      else row_reg = v;
    endfunction

    function int clamp(logic [4:0] v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function bit area_free(int x0, int y0, int w, int h, int cols);
      for (int y = y0; y < y0 + h; y++)
        for (int x = x0; x < x0 + w; x++)
          if (cells[y * cols + x] != 0) return 0;
      return 1;
    endfunction

    function void note_request(grfa_pkg::in_item_t r);
      grfa_pkg::out_item_t a;
      int cols, rows, w, h;
      bit found;
      cols = clamp(col_reg, grfa_pkg::MAX_COLUMNS);
      rows = clamp(row_reg, grfa_pkg::MAX_ROWS);
      w = r.item_width;
      h = r.item_height;
      a = '0;
      a.status = grfa_pkg::ST_FAIL;
      found = 0;
      case (r.mode)
        grfa_pkg::MODE_ADD: begin
          if (r.item_id == 0) a.status = grfa_pkg::ST_BADID;
          else if (w != 0 && h != 0 && w <= cols && h <= rows) begin
            for (int y = 0; y + h <= rows && !found; y++)
              for (int x = 0; x + w <= cols && !found; x++)
                if (area_free(x, y, w, h, cols)) begin
                  for (int b = y; b < y + h; b++)
                    for (int c = x; c < x + w; c++) cells[b * cols + c] = r.item_id;
                  a.placed_column = 4'(x);
                  a.placed_row = 4'(y);
                  a.status = grfa_pkg::ST_OK;
                  found = 1;
                end
          end
        end
        grfa_pkg::MODE_REMOVE: begin
          if (r.item_id == 0) a.status = grfa_pkg::ST_BADID;
          else
            foreach (cells[i])
              if (cells[i] == r.item_id) begin
                cells[i] = '0;
                a.status = grfa_pkg::ST_OK;
              end
        end
        grfa_pkg::MODE_LOOKUP: begin
          if (r.cell_index < cols * rows) begin
            a.cell_owner = cells[r.cell_index];
            a.status = grfa_pkg::ST_OK;
          end
        end
        default: ;
      endcase
      answers.push_back(a);
    endfunction

    function void check_result(grfa_pkg::out_item_t got);
      grfa_pkg::out_item_t exp_r;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        fails++;
        return;
      end
      exp_r = answers.pop_front();
      if (got.status !== exp_r.status || got.placed_column !== exp_r.placed_column ||
          got.placed_row !== exp_r.placed_row || got.cell_owner !== exp_r.cell_owner) begin
        $display("%0t: result mismatch, expected %p, got %p", $time, exp_r, got);
        fails++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  grfa_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  grfa_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic cfg_index = grfa_pkg::REG_COLS;
  logic [4:0] cfg_data = '0;

  grid_scoreboard sb = new();
  int idle_mode = 0;   // 0: sender 20 / receiver 86, 1: reverse, 2: none
  int hold_req = 0;
  int hold_cnt = 0;
  int cycles = 0;
  int cur_cols = 8, cur_rows = 4;

  grid_rectangle_first_fit_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("grid_rectangle_first_fit_allocator verification failed");
      $finish;
    end
  end

  // receiver: checks each transfer out and stalls at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (hold_req > 0 && hold_cnt == 0) begin
      hold_cnt <= hold_req;
      hold_req <= 0;
      out_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 0;
    end else if (idle_mode == 0) out_ready <= ($urandom_range(0, 99) >= 86);
    else if (idle_mode == 1) out_ready <= ($urandom_range(0, 99) >= 20);
    else out_ready <= 1;
  end

  task automatic send(grfa_pkg::in_item_t r);
    int pct;
    pct = (idle_mode == 0) ? 20 : (idle_mode == 1) ? 86 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  task automatic req(logic [1:0] m, logic [7:0] id, logic [4:0] w, logic [4:0] h,
                     logic [7:0] idx);
    grfa_pkg::in_item_t r;
    r.mode = m;
    r.item_id = id;
    r.item_width = w;
    r.item_height = h;
    r.cell_index = idx;
    send(r);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.configure(idx, v);
  endtask

  function automatic int dim_pick(int lim);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(1, (lim < 4) ? lim : 4);
    if (sel < 90) return lim;
    return $urandom_range(0, 31);
  endfunction

  task automatic random_request();
    grfa_pkg::in_item_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.mode = (sel < 45) ? grfa_pkg::MODE_ADD : (sel < 65) ? grfa_pkg::MODE_REMOVE :
             (sel < 95) ? grfa_pkg::MODE_LOOKUP : grfa_pkg::MODE_NONE;
    sel = $urandom_range(0, 99);
    r.item_id = (sel < 5) ? 8'd0 : (sel < 15) ? 8'($urandom) : 8'($urandom_range(1, 12));
    r.item_width = 5'(dim_pick(cur_cols));
    r.item_height = 5'(dim_pick(cur_rows));
    r.cell_index = ($urandom_range(0, 99) < 80) ?
                   8'($urandom_range(0, cur_cols * cur_rows - 1)) : 8'($urandom);
    send(r);
  endtask

  int col_set [NPHASE] = '{8, 1, 16, 0, 31, 5, 4, 16, 1};
  int row_set [NPHASE] = '{4, 1, 16, 0, 31, 3, 7, 1, 16};

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    // default 8 x 4 grid
    req(grfa_pkg::MODE_ADD, 8'd0, 5'd1, 5'd1, 8'd0);
    req(grfa_pkg::MODE_REMOVE, 8'd0, 5'd0, 5'd0, 8'd0);
    req(grfa_pkg::MODE_ADD, 8'd3, 5'd0, 5'd2, 8'd0);
    req(grfa_pkg::MODE_ADD, 8'd3, 5'd2, 5'd0, 8'd0);
    req(grfa_pkg::MODE_ADD, 8'd3, 5'd9, 5'd1, 8'd0);
    req(grfa_pkg::MODE_ADD, 8'd3, 5'd1, 5'd5, 8'd0);
    req(grfa_pkg::MODE_ADD, 8'd3, 5'd31, 5'd31, 8'd0);
    req(grfa_pkg::MODE_ADD, 8'd255, 5'd8, 5'd4, 8'd0);
    req(grfa_pkg::MODE_LOOKUP, 8'd0, 5'd0, 5'd0, 8'd0);
    req(grfa_pkg::MODE_LOOKUP, 8'd0, 5'd0, 5'd0, 8'd31);
    req(grfa_pkg::MODE_LOOKUP, 8'd0, 5'd0, 5'd0, 8'd32);
    req(grfa_pkg::MODE_LOOKUP, 8'd0, 5'd0, 5'd0, 8'd255);
    req(grfa_pkg::MODE_ADD, 8'd4, 5'd1, 5'd1, 8'd0);
    req(grfa_pkg::MODE_REMOVE, 8'd255, 5'd0, 5'd0, 8'd0);
    req(grfa_pkg::MODE_REMOVE, 8'd255, 5'd0, 5'd0, 8'd0);
    req(grfa_pkg::MODE_NONE, 8'hff, 5'h1f, 5'h1f, 8'hff);
    req(grfa_pkg::MODE_ADD, 8'd7, 5'd3, 5'd2, 8'd0);
    req(grfa_pkg::MODE_ADD, 8'd7, 5'd3, 5'd2, 8'd0);
    req(grfa_pkg::MODE_ADD, 8'd9, 5'd2, 5'd3, 8'd0);
    req(grfa_pkg::MODE_LOOKUP, 8'd0, 5'd0, 5'd0, 8'd3);
    req(grfa_pkg::MODE_REMOVE, 8'd7, 5'd0, 5'd0, 8'd0);
    req(grfa_pkg::MODE_LOOKUP, 8'd0, 5'd0, 5'd0, 8'd6);
    for (int p = 0; p < NPHASE; p++) begin
      idle_mode = p / 3;
      if (p > 0) begin
        drain();
        write_reg(grfa_pkg::REG_COLS, 5'(col_set[p]));
        write_reg(grfa_pkg::REG_ROWS, 5'(row_set[p]));
      end
      cur_cols = (col_set[p] == 0) ? 1 : (col_set[p] > 16) ? 16 : col_set[p];
      cur_rows = (row_set[p] == 0) ? 1 : (row_set[p] > 16) ? 16 : row_set[p];
      if (p == 6) hold_req = 400;
      repeat (98) random_request();
    end
    drain();
    repeat (40) @(posedge clk);
    if (sb.fails == 0 && sb.answers.size() == 0)
      $display("grid_rectangle_first_fit_allocator verification clean");
    else
      $display("grid_rectangle_first_fit_allocator verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/grfa_pkg.sv
rtl/grid_rectangle_first_fit_allocator.sv
rtl/grfa_checker.sv
dv/tb_grid_rectangle_first_fit_allocator.sv
